// ===== rtl/core/ftsr_pkg.sv =====
// Shared constants of the flat triangle span rasterizer: sequencer codes and field widths.
package ftsr_pkg;

  // operation codes of an input word
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_NEXT = 1'b1;

  // fixed-point format of the edge steppers
  localparam int FRAC_BITS = 16;
  localparam logic [15:0] FRAC_ONES = 16'hffff;

  // fixed widths of the result word
  localparam int ROW_W = 7;
  localparam int XCOL_W = 8;
  localparam int COLOR_W = 15;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CR1  = 3'd1;
  localparam logic [2:0] S_CR2  = 3'd2;
  localparam logic [2:0] S_SU   = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_SUDN = 3'd6;
  localparam logic [2:0] S_ADV  = 3'd7;

  // what an edge setup returns to
  localparam logic [2:0] C_LOAD_FIRST = 3'd0;
  localparam logic [2:0] C_LOAD_MID   = 3'd1;
  localparam logic [2:0] C_LOAD_RETRY = 3'd2;
  localparam logic [2:0] C_ADV_L      = 3'd3;
  localparam logic [2:0] C_ADV_R      = 3'd4;

endpackage

// ===== rtl/core/flat_triangle_span_rasterizer_core.sv =====
// Flat triangle span rasterizer: triangle load, edge setup by shared divider, row stepping.
//
// A load word sorts the vertices and sets up both edges; each edge setup runs a restoring
// divider at one quotient bit a cycle, followed by one multiply; a load runs a third setup
// when the middle edge has to be retried. A next-row word advances both edges and runs one
// more setup each time an edge enters a new section.
// The result word is shown once the row has been advanced; in_ready is high only while the
// sequencer is idle and the result register is free or being taken.
module flat_triangle_span_rasterizer_core
  import ftsr_pkg::*;
#(
  parameter int SCREEN_W = 160,
  parameter int SCREEN_H = 100,
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_operation,
  input  logic signed [COORD_BITS-1:0] in_ax,
  input  logic signed [COORD_BITS-1:0] in_ay,
  input  logic signed [COORD_BITS-1:0] in_bx,
  input  logic signed [COORD_BITS-1:0] in_by_coord,
  input  logic signed [COORD_BITS-1:0] in_cx,
  input  logic signed [COORD_BITS-1:0] in_cy,
  input  logic [COLOR_W-1:0]           in_fill_color,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_span_valid,
  output logic [ROW_W-1:0]             out_row,
  output logic [XCOL_W-1:0]            out_x_start,
  output logic [XCOL_W-1:0]            out_x_end,
  output logic [COLOR_W-1:0]           out_span_color,
  output logic                         out_done_res
);

  localparam int CB = COORD_BITS;
  localparam int QW = CB + 1 + FRAC_BITS;         // quotient / numerator magnitude
  localparam int CNT_W = $clog2(QW + 1);
  localparam int YW = CB + 2;                      // signed row arithmetic
  localparam int CR_W = $clog2(SCREEN_H + 1);
  localparam int PW = CB + 1 + QW + 1;
  localparam logic signed [YW-1:0] H_S = YW'(SCREEN_H);
  localparam logic signed [YW-1:0] H_M1 = YW'(SCREEN_H - 1);
  localparam logic signed [17:0] W_S = 18'(SCREEN_W);
  localparam logic signed [17:0] W_M1 = 18'(SCREEN_W - 1);

  // state
  logic [2:0] st_r, ctx_r;
  logic active_r, mid_r, er_r, su_ok_r;
  logic signed [CB-1:0] v0x_r, v0y_r, v1x_r, v1y_r, v2x_r, v2y_r;
  logic [31:0] lx_r, rx_r, lstep_r, rstep_r;
  logic signed [YW-1:0] lrows_r, rrows_r, srows_r;
  logic [1:0] lsec_r, rsec_r;
  logic [CR_W-1:0] crow_r;
  logic [COLOR_W-1:0] color_r;
  logic signed [2*CB+1:0] p1_r;
  logic [QW-1:0] q_r;
  logic [CB+1:0] rem_r;
  logic [CB:0] dv_r;
  logic [CNT_W-1:0] cnt_r;
  logic neg_r, adv_right_r;
  logic signed [CB:0] dy_r;
  logic signed [CB-1:0] tx_r;
  logic out_valid_r, o_span_r, o_done_r;
  logic [ROW_W-1:0] o_row_r;
  logic [XCOL_W-1:0] o_xs_r, o_xe_r;

  assign in_ready = (st_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_span_valid = o_span_r;
  assign out_row = o_row_r;
  assign out_x_start = o_xs_r;
  assign out_x_end = o_xe_r;
  assign out_span_color = color_r;
  assign out_done_res = o_done_r;

  // vertex sort by y
  logic signed [CB-1:0] s0x, s0y, s1x, s1y, s2x, s2y, tx, ty;
  always_comb begin
    s0x = in_ax; s0y = in_ay; s1x = in_bx; s1y = in_by_coord; s2x = in_cx; s2y = in_cy;
    if (s0y > s1y) begin
      tx = s0x; ty = s0y; s0x = s1x; s0y = s1y; s1x = tx; s1y = ty;
    end
    if (s0y > s2y) begin
      tx = s0x; ty = s0y; s0x = s2x; s0y = s2y; s2x = tx; s2y = ty;
    end
    if (s1y > s2y) begin
      tx = s1x; ty = s1y; s1x = s2x; s1y = s2y; s2x = tx; s2y = ty;
    end
    tx = s0x; ty = s0y;
  end

  logic drop;
  assign drop = (YW'(s0y) >= H_M1) || (s2y == s0y);

  // span of the current row
  logic signed [32:0] lsum, rsum;
  logic signed [16:0] x1;
  logic signed [17:0] x2, x1e, xs, xe;
  logic span_ok;
  always_comb begin
    lsum = signed'({lx_r[31], lx_r}) + signed'(33'(FRAC_ONES));
    rsum = signed'({rx_r[31], rx_r}) + signed'(33'(FRAC_ONES));
    x1 = lsum[32:16];
    x2 = 18'(signed'(rsum[32:16])) - 18'sd1;
    x1e = 18'(x1);
    xs = '0;
    xe = '0;
    span_ok = 1'b0;
    if (!(x1e < 0 && x2 < 0) && !(x1e >= W_S && x2 >= W_S)) begin
      xs = (x1e < 0) ? 18'sd0 : x1e;
      xe = (x2 > W_M1) ? W_M1 : x2;
      span_ok = xs <= xe;
    end
    if (!span_ok) begin
      xs = '0; xe = '0;
    end
  end

  // edge setup geometry
  logic [1:0] sec;
  logic hm, idx_ok;
  logic signed [CB-1:0] tpx, tpy, btx, bty;
  logic signed [CB:0] h, dx, dy;
  logic [CB:0] dxm;
  logic signed [YW-1:0] rows, ylo, yhi;
  always_comb begin
    sec = er_r ? rsec_r : lsec_r;
    hm = (er_r == mid_r);
    idx_ok = (sec == 2'd1) || (sec == 2'd2 && hm);
    tpx = v0x_r; tpy = v0y_r; btx = v2x_r; bty = v2y_r;
    if (hm && sec == 2'd1) begin
      tpx = v1x_r; tpy = v1y_r;
    end else if (hm) begin
      btx = v1x_r; bty = v1y_r;
    end
    h = (CB+1)'(bty) - (CB+1)'(tpy);
    dx = (CB+1)'(btx) - (CB+1)'(tpx);
    dxm = (dx < 0) ? unsigned'(-dx) : unsigned'(dx);
    dy = (tpy < 0) ? -(CB+1)'(tpy) : '0;
    ylo = (tpy < 0) ? '0 : YW'(tpy);
    yhi = (YW'(bty) < H_S) ? YW'(bty) : H_S;
    rows = yhi - ylo;
  end

  // divider step
  logic [CB+1:0] rsh;
  logic rge;
  assign rsh = {rem_r[CB:0], q_r[QW-1]};
  assign rge = rsh >= (CB+2)'(dv_r);

  // step and start x of the new section
  logic signed [QW:0] stp;
  logic signed [PW-1:0] prod;
  logic [31:0] xnew;
  always_comb begin
    stp = neg_r ? -signed'({1'b0, q_r}) : signed'({1'b0, q_r});
    prod = dy_r * stp;
    xnew = unsigned'(32'(tx_r) <<< FRAC_BITS) + prod[31:0];
  end

  // row advance of one edge
  logic signed [YW-1:0] arows;
  logic [1:0] asec;
  assign arows = (adv_right_r ? rrows_r : lrows_r) - YW'(1);
  assign asec = adv_right_r ? rsec_r : lsec_r;

  logic signed [2*CB+1:0] tri_cross;
  assign tri_cross = p1_r - ((2*CB+2)'((CB+1)'(v1y_r) - (CB+1)'(v0y_r)) *
                             (2*CB+2)'((CB+1)'(v2x_r) - (CB+1)'(v0x_r)));

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ctx_r <= C_LOAD_FIRST;
      active_r <= 1'b0;
      mid_r <= 1'b0;
      er_r <= 1'b0;
      su_ok_r <= 1'b0;
      adv_right_r <= 1'b0;
      lsec_r <= '0;
      rsec_r <= '0;
      lrows_r <= '0;
      rrows_r <= '0;
      lx_r <= '0;
      rx_r <= '0;
      lstep_r <= '0;
      rstep_r <= '0;
      crow_r <= '0;
      color_r <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (in_operation == OP_LOAD) begin
              active_r <= 1'b0;
              v0x_r <= s0x; v0y_r <= s0y; v1x_r <= s1x; v1y_r <= s1y;
              v2x_r <= s2x; v2y_r <= s2y;
              color_r <= in_fill_color;
              if (!drop) st_r <= S_CR1;
            end else if (active_r) begin
              o_span_r <= span_ok;
              o_row_r <= ROW_W'(crow_r);
              o_xs_r <= xs[XCOL_W-1:0];
              o_xe_r <= xe[XCOL_W-1:0];
              adv_right_r <= 1'b0;
              st_r <= S_ADV;
            end
          end
        end
        S_CR1: begin
          p1_r <= (2*CB+2)'((CB+1)'(v1x_r) - (CB+1)'(v0x_r)) *
                  (2*CB+2)'((CB+1)'(v2y_r) - (CB+1)'(v0y_r));
          st_r <= S_CR2;
        end
        S_CR2: begin
          mid_r <= tri_cross > 0;
          lsec_r <= (tri_cross > 0) ? 2'd1 : 2'd2;
          rsec_r <= (tri_cross > 0) ? 2'd2 : 2'd1;
          er_r <= !(tri_cross > 0);
          ctx_r <= C_LOAD_FIRST;
          st_r <= S_SU;
        end
        S_SU: begin
          if (!idx_ok || h == 0) begin
            su_ok_r <= 1'b0;
            st_r <= S_SUDN;
          end else begin
            q_r <= QW'({dxm, {FRAC_BITS{1'b0}}});
            rem_r <= '0;
            dv_r <= unsigned'(h);
            neg_r <= dx < 0;
            cnt_r <= CNT_W'(QW);
            dy_r <= dy;
            tx_r <= tpx;
            srows_r <= rows;
            st_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= rge ? rsh - (CB+2)'(dv_r) : rsh;
          q_r <= {q_r[QW-2:0], rge};
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) st_r <= S_MUL;
        end
        S_MUL: begin
          if (er_r) begin
            rstep_r <= 32'(stp); rx_r <= xnew; rrows_r <= srows_r;
          end else begin
            lstep_r <= 32'(stp); lx_r <= xnew; lrows_r <= srows_r;
          end
          su_ok_r <= srows_r > 0;
          st_r <= S_SUDN;
        end
        S_SUDN: begin
          case (ctx_r)
            C_LOAD_FIRST: begin
              if (su_ok_r) begin
                er_r <= mid_r;
                ctx_r <= C_LOAD_MID;
                st_r <= S_SU;
              end else begin
                st_r <= S_IDLE;
              end
            end
            C_LOAD_MID, C_LOAD_RETRY: begin
              if (su_ok_r) begin
                active_r <= 1'b1;
                crow_r <= (v0y_r < 0) ? '0 : CR_W'(v0y_r);
                st_r <= S_IDLE;
              end else if (ctx_r == C_LOAD_MID) begin
                if (mid_r) rsec_r <= 2'd1; else lsec_r <= 2'd1;
                ctx_r <= C_LOAD_RETRY;
                st_r <= S_SU;
              end else begin
                st_r <= S_IDLE;
              end
            end
            C_ADV_L: begin
              if (su_ok_r) begin
                adv_right_r <= 1'b1;
                st_r <= S_ADV;
              end else begin
                active_r <= 1'b0; o_done_r <= 1'b1; out_valid_r <= 1'b1;
                st_r <= S_IDLE;
              end
            end
            default: begin
              if (su_ok_r) crow_r <= crow_r + CR_W'(1);
              else active_r <= 1'b0;
              o_done_r <= !su_ok_r;
              out_valid_r <= 1'b1;
              st_r <= S_IDLE;
            end
          endcase
        end
        S_ADV: begin
          if (adv_right_r) rrows_r <= arows; else lrows_r <= arows;
          if (arows <= 0) begin
            if (asec <= 2'd1) begin
              if (adv_right_r) rsec_r <= '0; else lsec_r <= '0;
              active_r <= 1'b0; o_done_r <= 1'b1; out_valid_r <= 1'b1;
              st_r <= S_IDLE;
            end else begin
              if (adv_right_r) rsec_r <= asec - 2'd1; else lsec_r <= asec - 2'd1;
              er_r <= adv_right_r;
              ctx_r <= adv_right_r ? C_ADV_R : C_ADV_L;
              st_r <= S_SU;
            end
          end else begin
            if (adv_right_r) begin
              rx_r <= rx_r + rstep_r;
              crow_r <= crow_r + CR_W'(1);
              o_done_r <= 1'b0; out_valid_r <= 1'b1;
              st_r <= S_IDLE;
            end else begin
              lx_r <= lx_r + lstep_r;
              adv_right_r <= 1'b1;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> st_r == S_IDLE) else $error("ready outside idle");
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DIV |=> (st_r == S_DIV || st_r == S_MUL)) else $error("divider left early");
  a_active_sec: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && st_r == S_IDLE) |-> (lsec_r != 2'd0 && rsec_r != 2'd0))
    else $error("active with a spent edge");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r) else $error("result dropped");

endmodule

// ===== dv/flat_triangle_span_rasterizer_core_test.sv =====
// Self-checking testbench of the flat triangle span rasterizer core.
module flat_triangle_span_rasterizer_core_test;
  import ftsr_pkg::*;

  localparam int SCR_W = 160;
  localparam int SCR_H = 100;
  localparam int CB = 12;
  localparam int N_WORDS = 400;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic op;
    logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
    logic [COLOR_W-1:0] color;
    bit drain;
  } tri_word_t;

  typedef struct {
    logic span_valid;
    logic [ROW_W-1:0] row;
    logic [XCOL_W-1:0] xs, xe;
    logic [COLOR_W-1:0] color;
    logic done;
  } span_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = OP_LOAD;
  logic signed [CB-1:0] in_ax = '0, in_ay = '0, in_bx = '0, in_by_coord = '0;
  logic signed [CB-1:0] in_cx = '0, in_cy = '0;
  logic [COLOR_W-1:0] in_fill_color = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_span_valid;
  logic [ROW_W-1:0] out_row;
  logic [XCOL_W-1:0] out_x_start, out_x_end;
  logic [COLOR_W-1:0] out_span_color;
  logic out_done_res;

  always #2 clk = ~clk;

  flat_triangle_span_rasterizer_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_ax(in_ax), .in_ay(in_ay), .in_bx(in_bx), .in_by_coord(in_by_coord),
    .in_cx(in_cx), .in_cy(in_cy), .in_fill_color(in_fill_color),
    .out_valid(out_valid), .out_ready(out_ready), .out_span_valid(out_span_valid),
    .out_row(out_row), .out_x_start(out_x_start), .out_x_end(out_x_end),
    .out_span_color(out_span_color), .out_done_res(out_done_res)
  );

  tri_word_t pending_words[$];
  span_t spans_due[$];
  int errors = 0;
  int words_taken = 0, loads_taken = 0, spans_seen = 0, visible_seen = 0, tris_done = 0;
  bit in_took = 0;

  // rasterizer state mirror
  bit tri_active = 0;
  int vx[3], vy[3];
  bit mid_right = 0;
  bit [31:0] l_x = 0, r_x = 0, l_step = 0, r_step = 0;
  int l_rows = 0, r_rows = 0, l_sec = 0, r_sec = 0;
  int cur_row = 0;
  logic [COLOR_W-1:0] cur_color = '0;

  function automatic int chain_idx(bit has_mid, int k);
    if (has_mid) return 2 - k;
    return (k == 0) ? 2 : 0;
  endfunction

  // set up one edge section, returns its visible row count
  function automatic int edge_setup(bit rside);
    int sec;
    bit has_mid;
    int ti, bi;
    longint h, stp, dy, rows;
    bit [31:0] x;
    sec = rside ? r_sec : l_sec;
    has_mid = (rside == mid_right);
    if (sec < 1 || sec > 2 || (!has_mid && sec != 1)) return 0;
    ti = chain_idx(has_mid, sec);
    bi = chain_idx(has_mid, sec - 1);
    h = longint'(vy[bi]) - vy[ti];
    if (h == 0) return 0;
    stp = (longint'(vx[bi] - vx[ti]) * 65536) / h;
    dy = (vy[ti] < 0) ? -vy[ti] : 0;
    x = 32'(longint'(vx[ti]) * 65536) + 32'(dy * stp);
    rows = ((vy[bi] < SCR_H) ? vy[bi] : SCR_H) - ((vy[ti] > 0) ? vy[ti] : 0);
    if (rside) begin
      r_step = 32'(stp); r_x = x; r_rows = int'(rows);
    end else begin
      l_step = 32'(stp); l_x = x; l_rows = int'(rows);
    end
    return int'(rows);
  endfunction

  function automatic void tri_load(tri_word_t w);
    int tx, ty;
    longint tri_cross;
    vx[0] = w.ax; vy[0] = w.ay; vx[1] = w.bx; vy[1] = w.by; vx[2] = w.cx; vy[2] = w.cy;
    if (vy[0] > vy[1]) begin
      tx = vx[0]; ty = vy[0]; vx[0] = vx[1]; vy[0] = vy[1]; vx[1] = tx; vy[1] = ty;
    end
    if (vy[0] > vy[2]) begin
      tx = vx[0]; ty = vy[0]; vx[0] = vx[2]; vy[0] = vy[2]; vx[2] = tx; vy[2] = ty;
    end
    if (vy[1] > vy[2]) begin
      tx = vx[1]; ty = vy[1]; vx[1] = vx[2]; vy[1] = vy[2]; vx[2] = tx; vy[2] = ty;
    end
    tri_active = 0;
    cur_color = w.color;
    if (vy[0] >= SCR_H - 1 || vy[2] == vy[0]) return;
    tri_cross = longint'(vx[1] - vx[0]) * (vy[2] - vy[0])
              - longint'(vy[1] - vy[0]) * (vx[2] - vx[0]);
    mid_right = tri_cross > 0;
    if (mid_right) begin r_sec = 2; l_sec = 1; end
    else begin l_sec = 2; r_sec = 1; end
    if (edge_setup(!mid_right) <= 0) return;
    if (edge_setup(mid_right) <= 0) begin
      if (mid_right) r_sec = 1; else l_sec = 1;
      if (edge_setup(mid_right) <= 0) return;
    end
    cur_row = (vy[0] > 0) ? vy[0] : 0;
    tri_active = 1;
  endfunction

  function automatic bit edge_advance(bit rside);
    if (rside) begin
      r_rows--;
      if (r_rows <= 0) begin
        if (r_sec <= 1) begin r_sec = 0; return 0; end
        r_sec--;
        return edge_setup(1) > 0;
      end
      r_x += r_step;
    end else begin
      l_rows--;
      if (l_rows <= 0) begin
        if (l_sec <= 1) begin l_sec = 0; return 0; end
        l_sec--;
        return edge_setup(0) > 0;
      end
      l_x += l_step;
    end
    return 1;
  endfunction

  // work out the span that one accepted word produces, if any
  function automatic void predict_span(tri_word_t w);
    longint x1, x2, xs, xe;
    bit vis;
    span_t s;
    if (w.op == OP_LOAD) begin
      tri_load(w);
      return;
    end
    if (!tri_active) return;
    x1 = (longint'($signed(l_x)) + 65535) >>> 16;
    x2 = ((longint'($signed(r_x)) + 65535) >>> 16) - 1;
    vis = 0; xs = 0; xe = 0;
    if (!(x1 < 0 && x2 < 0) && !(x1 >= SCR_W && x2 >= SCR_W)) begin
      xs = (x1 > 0) ? x1 : 0;
      xe = (x2 < SCR_W - 1) ? x2 : SCR_W - 1;
      vis = xs <= xe;
    end
    if (!vis) begin xs = 0; xe = 0; end
    s.span_valid = vis;
    s.row = ROW_W'(cur_row);
    s.xs = XCOL_W'(xs);
    s.xe = XCOL_W'(xe);
    s.color = cur_color;
    if (edge_advance(0) && edge_advance(1)) begin
      cur_row++;
      s.done = 0;
    end else begin
      tri_active = 0;
      s.done = 1;
    end
    spans_due.push_back(s);
  endfunction

  // input acceptance, prediction and result checking on the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      tri_word_t w;
      w.op = in_operation; w.ax = in_ax; w.ay = in_ay; w.bx = in_bx; w.by = in_by_coord;
      w.cx = in_cx; w.cy = in_cy; w.color = in_fill_color; w.drain = 0;
      predict_span(w);
      in_took = 1;
      words_taken++;
      if (w.op == OP_LOAD) loads_taken++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (spans_due.size() == 0) begin
        $error("unexpected result word: row %0d", out_row);
        errors++;
      end else begin
        span_t e;
        e = spans_due.pop_front();
        spans_seen++;
        if (e.span_valid) visible_seen++;
        if (e.done) tris_done++;
        if (out_span_valid !== e.span_valid) begin
          $error("span_valid: expected %0d, got %0d", e.span_valid, out_span_valid); errors++;
        end
        if (out_row !== e.row) begin
          $error("row: expected %0d, got %0d", e.row, out_row); errors++;
        end
        if (out_x_start !== e.xs) begin
          $error("x_start: expected %0d, got %0d", e.xs, out_x_start); errors++;
        end
        if (out_x_end !== e.xe) begin
          $error("x_end: expected %0d, got %0d", e.xe, out_x_end); errors++;
        end
        if (out_span_color !== e.color) begin
          $error("span_color: expected %h, got %h", e.color, out_span_color); errors++;
        end
        if (out_done_res !== e.done) begin
          $error("done_res: expected %0d, got %0d", e.done, out_done_res); errors++;
        end
      end
    end
  end

  // sender: bursts and gaps, plus a pause for a full drain where asked
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0 &&
                   !(pending_words[0].drain && spans_due.size() > 0)) begin
        tri_word_t w;
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        in_operation <= w.op;
        in_ax <= w.ax; in_ay <= w.ay; in_bx <= w.bx; in_by_coord <= w.by;
        in_cx <= w.cx; in_cy <= w.cy; in_fill_color <= w.color;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(20);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_took = 0;
  end

  // receiver: windows of free flow or random stalls, one long hold-off
  int hold_left = 0, window_left = 0, ready_mode = 0;
  bit held_once = 0;
  always @(negedge clk) begin
    if (!held_once && words_taken >= 120) begin
      held_once = 1;
      hold_left = 400;
    end
    if (window_left == 0) begin
      window_left = $urandom_range(80, 10);
      ready_mode = $urandom_range(2);
    end else window_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (ready_mode == 0) out_ready <= 1'b1;
    else if (ready_mode == 1) out_ready <= ($urandom_range(1) == 1);
    else out_ready <= ($urandom_range(7) == 0);
  end

  // run limit
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic tri_word_t mk(logic op, int ax, int ay, int bx, int by, int cx, int cy,
                                   int color);
    tri_word_t w;
    w.op = op; w.ax = CB'(ax); w.ay = CB'(ay); w.bx = CB'(bx); w.by = CB'(by);
    w.cx = CB'(cx); w.cy = CB'(cy); w.color = COLOR_W'(color); w.drain = 0;
    return w;
  endfunction

  function automatic int rnd(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic tri_word_t rnd_full(logic op);
    return mk(op, rnd(-2048, 2047), rnd(-2048, 2047), rnd(-2048, 2047), rnd(-2048, 2047),
              rnd(-2048, 2047), rnd(-2048, 2047), $urandom_range(32767));
  endfunction

  function automatic void push_nexts(int n);
    repeat (n) pending_words.push_back(rnd_full(OP_NEXT));
  endfunction

  initial begin
    int queued;
    int ty, hh;
    tri_word_t w;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: next while idle, ordinary triangles, clipping and dropping cases
    pending_words.push_back(mk(OP_NEXT, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_LOAD, 10, 5, 40, 12, 20, 15, 32767));     // middle right
    push_nexts(11);
    pending_words.push_back(mk(OP_LOAD, 60, 2, 30, 8, 70, 12, 21845));     // middle left
    push_nexts(3);
    pending_words.push_back(mk(OP_LOAD, 0, 0, 0, 0, 0, 0, 0));             // load while active
    pending_words.push_back(mk(OP_LOAD, -50, 10, -20, 14, -30, 18, 1));     // left of screen
    push_nexts(2);
    pending_words.push_back(mk(OP_LOAD, 170, 10, 200, 14, 300, 18, 2));     // right of screen
    push_nexts(2);
    pending_words.push_back(mk(OP_LOAD, 5, 99, 50, 120, 9, 140, 3));       // starts on last row
    pending_words.push_back(mk(OP_LOAD, 5, 40, 50, 40, 90, 40, 4));         // zero height
    pending_words.push_back(mk(OP_LOAD, 10, 50, 11, 55, 10, 60, 5));        // thin, reversed
    push_nexts(5);
    pending_words.push_back(mk(OP_LOAD, 10, -5, 90, -5, 50, 3, 6));         // flat top, clipped
    push_nexts(3);
    pending_words.push_back(mk(OP_LOAD, -2048, -2048, 2047, 2047, -2048, 2047, 32767));
    push_nexts(4);
    pending_words.push_back(mk(OP_LOAD, 2047, -2048, -2048, 2047, 2047, 2047, 0));
    push_nexts(100);
    w = mk(OP_LOAD, 80, 95, 60, 120, 100, 110, 7);                           // bottom clipped
    w.drain = 1;
    pending_words.push_back(w);
    push_nexts(6);

    // random: mostly loads followed by runs of next-row words, some noise
    queued = pending_words.size();
    while (queued < N_WORDS) begin
      if ($urandom_range(9) == 0) begin
        w = rnd_full($urandom_range(1) ? OP_LOAD : OP_NEXT);
        pending_words.push_back(w);
        queued++;
      end else begin
        ty = rnd(-20, 104);
        hh = ($urandom_range(7) == 0) ? rnd(0, 120) : rnd(0, 18);
        w = mk(OP_LOAD, rnd(-40, 200), ty + rnd(0, hh), rnd(-40, 200), ty + rnd(0, hh),
               rnd(-40, 200), ty + hh, $urandom_range(32767));
        w.drain = ($urandom_range(15) == 0);
        pending_words.push_back(w);
        hh = rnd(1, 24);
        push_nexts(hh);
        queued += hh + 1;
      end
    end

    wait (pending_words.size() == 0 && !in_valid);
    wait (spans_due.size() == 0);
    repeat (200) @(posedge clk);
    $display("words taken %0d (loads %0d), spans checked %0d, visible %0d, triangles ended %0d",
             words_taken, loads_taken, spans_seen, visible_seen, tris_done);
    if (errors == 0 && spans_due.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
